// ===== src/complete_binary_tree_traversal_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary tree traversal block
// Shared property shapes used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMPLETE_BINARY_TREE_TRAVERSAL_TOP_DEFINES_SVH
`define COMPLETE_BINARY_TREE_TRAVERSAL_TOP_DEFINES_SVH

// Same-cycle implication, quiet while in reset.
`define CBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while in reset.
`define CBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Types, codes and microcode word layout for the binary tree traversal block.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int MAX_NODES_DEF   = 32;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int VALUE_W     = 16;
  localparam int POS_W       = 6;
  localparam int CHILD_W     = POS_W + 1;
  localparam int STACK_DEPTH = 6;
  localparam int DEPTH_W     = 3;

  // Operation codes
  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_APPEND   = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;

  // Walk orders
  localparam logic [2:0] ORDER_MIRROR_PRE = 3'd3;
  localparam logic [2:0] ORDER_LAST       = 3'd5;

  // Visit phases held with each stack entry
  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_VISIT = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [VALUE_W-1:0] node_value;
    logic [2:0]         walk_order;
  } cbt_in_t;

  typedef struct packed {
    logic [VALUE_W-1:0] out_value;
    logic [POS_W-1:0]   out_position;
    logic [1:0]         status;
    logic               last;
  } cbt_out_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [POS_W-1:0] pos;
  } stk_entry_t;

  // Microprogram addresses
  typedef logic [1:0] upc_t;
  localparam upc_t UA_IDLE  = 2'd0;
  localparam upc_t UA_FETCH = 2'd1;
  localparam upc_t UA_VISIT = 2'd2;
  localparam upc_t UA_FLUSH = 2'd3;

  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_START,
    COND_DONE
  } cond_t;

  typedef struct packed {
    logic  accept_en;
    logic  fetch_en;
    logic  visit_en;
    logic  flush_en;
    cond_t cond;
    upc_t  tgt_true;
    upc_t  tgt_false;
  } ucode_t;

  typedef struct packed {
    logic start;
    logic done;
    logic hold;
  } seq_stat_t;

endpackage

// ===== src/cbt_seq.sv =====
// ----------------------------------------------------------------------------
// cbt_seq
// Microcode sequencer: control ROM, step counter and conditional jumps.
// ----------------------------------------------------------------------------
module cbt_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  cbt_pkg::seq_stat_t stat,
  output cbt_pkg::ucode_t    ctrl
);
  import cbt_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic take;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t w;
    w = '0;
    case (addr)
      UA_IDLE: begin
        w.accept_en = 1'b1;
        w.cond      = COND_START;
        w.tgt_true  = UA_FETCH;
        w.tgt_false = UA_IDLE;
      end
      UA_FETCH: begin
        w.fetch_en  = 1'b1;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = UA_VISIT;
        w.tgt_false = UA_VISIT;
      end
      UA_VISIT: begin
        w.visit_en  = 1'b1;
        w.cond      = COND_DONE;
        w.tgt_true  = UA_FLUSH;
        w.tgt_false = UA_FETCH;
      end
      UA_FLUSH: begin
        w.flush_en  = 1'b1;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = UA_IDLE;
        w.tgt_false = UA_IDLE;
      end
      default: begin
        w.accept_en = 1'b1;
        w.cond      = COND_ALWAYS;
        w.tgt_true  = UA_IDLE;
        w.tgt_false = UA_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctrl = ucode_rom(upc_r);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS: take = 1'b1;
      COND_START:  take = stat.start;
      COND_DONE:   take = stat.done;
      default:     take = 1'b1;
    endcase
    if (stat.hold) begin
      upc_nxt = upc_r;
    end else if (take) begin
      upc_nxt = ctrl.tgt_true;
    end else begin
      upc_nxt = ctrl.tgt_false;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== src/cbt_dp.sv =====
// ----------------------------------------------------------------------------
// cbt_dp
// Datapath: node memory, walk stack, pending result and output register.
// ----------------------------------------------------------------------------
module cbt_dp #(
  parameter int MAX_NODES   = cbt_pkg::MAX_NODES_DEF,
  parameter int VALUE_WIDTH = cbt_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cbt_pkg::ucode_t    ctrl,
  output cbt_pkg::seq_stat_t stat,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbt_pkg::cbt_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbt_pkg::cbt_out_t  out_data
);
  import cbt_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int SW = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;

  logic [SW-1:0]      node_mem [MAX_NODES];
  logic [SW-1:0]      rd_data_r;
  logic [CW-1:0]      count_r, count_nxt;
  stk_entry_t         walk_stack_r [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [DEPTH_W-1:0] top_idx;
  stk_entry_t         top_ent;
  logic [POS_W-1:0]   top_pos_r;
  logic [1:0]         top_phase_r;
  logic               emit_r;
  logic [1:0]         kind_r;
  logic               mirror_r;
  logic               pend_valid_r, pend_valid_nxt;
  logic [SW-1:0]      pend_value_r;
  logic [POS_W-1:0]   pend_pos_r;
  logic               out_valid_r, out_valid_nxt;
  cbt_out_t           out_data_r;
  cbt_out_t           out_new;
  logic               out_load;
  logic               out_free;
  logic               accept;
  logic               mem_we;
  logic               walk_init;
  logic               top_wr;
  stk_entry_t         top_new;
  logic               push_en;
  logic [CHILD_W-1:0] child_sel;
  logic [POS_W-1:0]   pos_m1;
  logic               visit_go;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = ctrl.accept_en && out_free;
  assign accept   = in_valid && in_ready;
  assign top_idx  = depth_r - DEPTH_W'(1);
  assign top_ent  = walk_stack_r[top_idx];
  assign pos_m1   = top_ent.pos - POS_W'(1);

  always_comb begin
    count_nxt      = count_r;
    depth_nxt      = depth_r;
    pend_valid_nxt = pend_valid_r;
    out_load       = 1'b0;
    out_new        = '0;
    mem_we         = 1'b0;
    walk_init      = 1'b0;
    top_wr         = 1'b0;
    top_new        = '0;
    push_en        = 1'b0;
    child_sel      = '0;
    visit_go       = 1'b0;
    stat           = '0;

    if (accept) begin
      case (in_data.operation)
        OP_CLEAR: begin
          count_nxt = '0;
        end
        OP_APPEND: begin
          if (count_r == CW'(MAX_NODES)) begin
            out_load       = 1'b1;
            out_new.status = ST_FULL;
            out_new.last   = 1'b1;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        OP_TRAVERSE: begin
          if (in_data.walk_order <= ORDER_LAST) begin
            if (count_r == '0) begin
              out_load       = 1'b1;
              out_new.status = ST_EMPTY;
              out_new.last   = 1'b1;
            end else begin
              walk_init  = 1'b1;
              depth_nxt  = DEPTH_W'(1);
              stat.start = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (ctrl.visit_en) begin
      stat.hold = emit_r && pend_valid_r && !out_free;
      visit_go  = !stat.hold;
      stat.done = (top_phase_r >= PH_DONE) && (depth_r == DEPTH_W'(1));
      if (visit_go) begin
        // Release the older node; the new one waits until we know if it is last.
        if (emit_r) begin
          pend_valid_nxt = 1'b1;
          if (pend_valid_r) begin
            out_load             = 1'b1;
            out_new.out_value    = VALUE_W'(pend_value_r);
            out_new.out_position = pend_pos_r;
            out_new.status       = ST_VISIT;
          end
        end
        top_new.pos = top_pos_r;
        if (top_phase_r == PH_FIRST) begin
          top_wr        = 1'b1;
          top_new.phase = PH_SECOND;
          child_sel     = mirror_r ? {top_pos_r, 1'b1} : {top_pos_r, 1'b0};
        end else if (top_phase_r == PH_SECOND) begin
          top_wr        = 1'b1;
          top_new.phase = PH_DONE;
          child_sel     = mirror_r ? {top_pos_r, 1'b0} : {top_pos_r, 1'b1};
        end else begin
          depth_nxt = depth_r - DEPTH_W'(1);
        end
        if (top_wr && (child_sel <= CHILD_W'(count_r)) &&
            (depth_r < DEPTH_W'(STACK_DEPTH))) begin
          push_en   = 1'b1;
          depth_nxt = depth_r + DEPTH_W'(1);
        end
      end
    end

    if (ctrl.flush_en) begin
      stat.hold = !out_free;
      if (out_free) begin
        out_load             = 1'b1;
        out_new.out_value    = VALUE_W'(pend_value_r);
        out_new.out_position = pend_pos_r;
        out_new.status       = ST_VISIT;
        out_new.last         = 1'b1;
        pend_valid_nxt       = 1'b0;
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[count_r[AW-1:0]] <= in_data.node_value[SW-1:0];
    end
    if (ctrl.fetch_en) begin
      rd_data_r <= node_mem[pos_m1[AW-1:0]];
    end
  end

  // Walk stack and per-step payload
  always_ff @(posedge clk) begin
    if (walk_init) begin
      walk_stack_r[0] <= '{phase: PH_FIRST, pos: POS_W'(1)};
      mirror_r        <= (in_data.walk_order >= ORDER_MIRROR_PRE);
      kind_r          <= (in_data.walk_order >= ORDER_MIRROR_PRE) ?
                         2'(in_data.walk_order - ORDER_MIRROR_PRE) :
                         2'(in_data.walk_order);
    end
    if (top_wr) begin
      walk_stack_r[top_idx] <= top_new;
    end
    if (push_en) begin
      walk_stack_r[depth_r] <= '{phase: PH_FIRST, pos: child_sel[POS_W-1:0]};
    end
    if (ctrl.fetch_en) begin
      top_pos_r   <= top_ent.pos;
      top_phase_r <= top_ent.phase;
      emit_r      <= (top_ent.phase == kind_r);
    end
    if (visit_go && emit_r) begin
      pend_value_r <= rd_data_r;
      pend_pos_r   <= top_pos_r;
    end
    if (out_load) begin
      out_data_r <= out_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      depth_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      depth_r      <= depth_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/complete_binary_tree_traversal_top.sv =====
// ----------------------------------------------------------------------------
// complete_binary_tree_traversal_top
// Level-order node store with six depth-first walks under microcode control.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready request channel carrying operation, node_value and
//           walk_order. Clear and append requests are taken one per cycle
//           while the result register is free and no walk is running.
//   out_* : valid/ready result channel; one registered result stage.
//   Append to a full store, and a traverse of an empty tree, give a single
//   result in the cycle after the request. A clear gives no result.
//   A traverse of N nodes runs three visit phases per node, each a fetch
//   step plus a visit step of the microprogram, before the next request
//   is taken. The first result of a walk of two or more nodes leaves
//   after the second emitted node is found; each result is held back one
//   visit so the final one can carry last.
//   A stalled receiver holds the walk at the next visit that must emit.
//   Reset empties the tree and returns the sequencer to its idle step; the
//   node memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "complete_binary_tree_traversal_top_defines.svh"

module complete_binary_tree_traversal_top #(
  parameter int MAX_NODES   = cbt_pkg::MAX_NODES_DEF,
  parameter int VALUE_WIDTH = cbt_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cbt_pkg::cbt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cbt_pkg::cbt_out_t out_data
);
  import cbt_pkg::*;

  ucode_t    ctrl;
  seq_stat_t stat;

  cbt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cbt_dp #(
    .MAX_NODES   (MAX_NODES),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `CBT_ASSERT_NEXT(a_start_fetch, clk, rst_n, stat.start && in_valid && in_ready, ctrl.fetch_en, "walk start did not enter fetch step")
  `CBT_ASSERT_NEXT(a_done_flush, clk, rst_n, ctrl.visit_en && stat.done && !stat.hold, ctrl.flush_en, "finished walk did not flush")
  `CBT_ASSERT_NEXT(a_flush_idle, clk, rst_n, ctrl.flush_en && !stat.hold, ctrl.accept_en && out_valid && out_data.last, "flush did not deliver last result")
  `CBT_ASSERT_NOW(a_ready_idle, clk, rst_n, in_ready, ctrl.accept_en && !stat.hold, "request taken outside idle step")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for complete_binary_tree_traversal_top
// Drives clear, append and traverse requests through the valid/ready channel.
// A scoreboard class keeps its own copy of the tree and works out each walk
// with an explicit stack. Every result is compared field by field in arrival
// order. The random part builds trees of random size and walks them in random
// orders. It runs through four idling phases on the request and result sides.
// ----------------------------------------------------------------------------
module testbench;
  import cbt_pkg::*;

  localparam int NODE_CAP     = MAX_NODES_DEF;
  localparam int STACK_LEVELS = STACK_DEPTH;
  localparam int DRAIN_CYCLES = 250;
  localparam int PHASE_ITEMS  = 65;

  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef enum logic [2:0] {
    WALK_PRE,
    WALK_IN,
    WALK_POST,
    WALK_MIRROR_PRE,
    WALK_MIRROR_IN,
    WALK_MIRROR_POST,
    WALK_BAD_SIX,
    WALK_BAD_SEVEN
  } walk_order_t;

  class tree_walk_predictor_t;
    logic [VALUE_W-1:0] node_vals [NODE_CAP];
    int                 node_total;
    cbt_out_t           due_results [$];
    int                 failures;

    function void predict_walk(logic [2:0] order);
      int         stk_pos [STACK_LEVELS];
      logic [1:0] stk_phase [STACK_LEVELS];
      int         depth;
      int         top;
      int         pos;
      int         first_child;
      int         second_child;
      logic [1:0] phase;
      logic [2:0] kind3;
      logic [1:0] emit_phase;
      bit         mirrored;
      bit         have_held;
      cbt_out_t   visit;
      cbt_out_t   held;
      mirrored = (order >= ORDER_MIRROR_PRE);
      kind3 = mirrored ? order - ORDER_MIRROR_PRE : order;
      emit_phase = kind3[1:0];
      stk_pos[0] = 1;
      stk_phase[0] = PH_FIRST;
      depth = 1;
      have_held = 0;
      held = '0;
      while (depth > 0) begin
        top = depth - 1;
        pos = stk_pos[top];
        phase = stk_phase[top];
        first_child  = mirrored ? 2 * pos + 1 : 2 * pos;
        second_child = mirrored ? 2 * pos : 2 * pos + 1;
        if (phase == emit_phase && pos >= 1 && pos <= node_total) begin
          visit = '0;
          visit.out_value = node_vals[pos-1];
          visit.out_position = pos[POS_W-1:0];
          visit.status = ST_VISIT;
          // hold each visit back one step so the final one can carry last
          if (have_held) due_results.push_back(held);
          held = visit;
          have_held = 1;
        end
        if (phase == PH_FIRST) begin
          stk_phase[top] = PH_SECOND;
          if (first_child <= node_total && depth < STACK_LEVELS) begin
            stk_pos[depth] = first_child;
            stk_phase[depth] = PH_FIRST;
            depth++;
          end
        end else if (phase == PH_SECOND) begin
          stk_phase[top] = PH_DONE;
          if (second_child <= node_total && depth < STACK_LEVELS) begin
            stk_pos[depth] = second_child;
            stk_phase[depth] = PH_FIRST;
            depth++;
          end
        end else begin
          depth--;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        due_results.push_back(held);
      end
    endfunction

    function void note_request(cbt_in_t req);
      cbt_out_t single;
      single = '0;
      single.last = 1'b1;
      case (req.operation)
        OP_CLEAR: begin
          node_total = 0;
        end
        OP_APPEND: begin
          if (node_total >= NODE_CAP) begin
            single.status = ST_FULL;
            due_results.push_back(single);
          end else begin
            node_vals[node_total] = req.node_value;
            node_total++;
          end
        end
        OP_TRAVERSE: begin
          if (req.walk_order <= ORDER_LAST) begin
            if (node_total == 0) begin
              single.status = ST_EMPTY;
              due_results.push_back(single);
            end else begin
              predict_walk(req.walk_order);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(cbt_out_t got);
      cbt_out_t exp;
      if (due_results.size() == 0) begin
        $error("unexpected result: value %h position %0d status %0d last %0b",
               got.out_value, got.out_position, got.status, got.last);
        failures++;
        return;
      end
      exp = due_results.pop_front();
      if (got.out_value !== exp.out_value) begin
        $error("out_value: expected %h, got %h", exp.out_value, got.out_value);
        failures++;
      end
      if (got.out_position !== exp.out_position) begin
        $error("out_position: expected %0d, got %0d", exp.out_position,
               got.out_position);
        failures++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        failures++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  cbt_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  cbt_out_t out_data;

  int send_idle_pct = 0;
  int stall_pct     = 0;

  tree_walk_predictor_t walk_pred;

  complete_binary_tree_traversal_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) walk_pred.check_result(out_data);
  end

  task automatic send_request(logic [1:0] op, logic [VALUE_W-1:0] value,
                              logic [2:0] order);
    cbt_in_t req;
    req.operation = op;
    req.node_value = value;
    req.walk_order = order;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    walk_pred.note_request(req);
  endtask

  // Mostly clear, fill, walk sequences; the rest is noise and stray clears.
  task automatic run_random_phase(int quota);
    int taken;
    int pick;
    int size_pick;
    int fill;
    int walks;
    taken = 0;
    while (taken < quota) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_request(OP_SPARE, VALUE_W'($urandom), 3'($urandom));
        taken++;
      end else if (pick < 10) begin
        send_request(OP_TRAVERSE, VALUE_W'($urandom),
                     3'($urandom_range(WALK_BAD_SIX, WALK_BAD_SEVEN)));
        taken++;
      end else if (pick < 16) begin
        send_request(OP_CLEAR, VALUE_W'($urandom), 3'($urandom));
        send_request(OP_TRAVERSE, VALUE_W'($urandom),
                     3'($urandom_range(WALK_PRE, WALK_MIRROR_POST)));
        taken += 2;
      end else begin
        if ($urandom_range(99) < 70) begin
          send_request(OP_CLEAR, VALUE_W'($urandom), 3'($urandom));
          taken++;
        end
        size_pick = $urandom_range(9);
        if (size_pick < 6) fill = $urandom_range(1, 7);
        else if (size_pick < 8) fill = $urandom_range(8, 20);
        else fill = $urandom_range(28, NODE_CAP + 3);
        repeat (fill) send_request(OP_APPEND, VALUE_W'($urandom), 3'($urandom));
        taken += fill;
        walks = $urandom_range(1, 3);
        repeat (walks) begin
          send_request(OP_TRAVERSE, VALUE_W'($urandom),
                       3'($urandom_range(WALK_PRE, WALK_MIRROR_POST)));
        end
        taken += walks;
      end
    end
  endtask

  initial begin
    walk_pred = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty tree, then a full three-level tree walked in all six orders
    send_request(OP_TRAVERSE, '0, WALK_PRE);
    send_request(OP_APPEND, 16'hFFFF, WALK_PRE);
    send_request(OP_APPEND, 16'h0000, WALK_BAD_SEVEN);
    send_request(OP_APPEND, 16'h1234, WALK_PRE);
    send_request(OP_APPEND, 16'hA5A5, WALK_PRE);
    send_request(OP_APPEND, 16'h5A5A, WALK_PRE);
    send_request(OP_APPEND, 16'h8001, WALK_PRE);
    send_request(OP_APPEND, 16'h7FFE, WALK_PRE);
    for (int o = WALK_PRE; o <= WALK_MIRROR_POST; o++) begin
      send_request(OP_TRAVERSE, 16'hFFFF, o[2:0]);
    end
    send_request(OP_TRAVERSE, '0, WALK_BAD_SIX);
    send_request(OP_TRAVERSE, '0, WALK_BAD_SEVEN);
    send_request(OP_SPARE, 16'hFFFF, WALK_IN);
    send_request(OP_CLEAR, 16'hFFFF, WALK_BAD_SEVEN);
    send_request(OP_TRAVERSE, '0, WALK_MIRROR_POST);
    // a lone root after clear
    send_request(OP_APPEND, 16'h0001, WALK_PRE);
    send_request(OP_TRAVERSE, '0, WALK_IN);

    send_idle_pct = 0;
    stall_pct = 0;
    run_random_phase(PHASE_ITEMS);
    send_idle_pct = 61;
    stall_pct = 0;
    run_random_phase(PHASE_ITEMS);
    send_idle_pct = 0;
    stall_pct = 61;
    run_random_phase(PHASE_ITEMS);
    send_idle_pct = 37;
    stall_pct = 37;
    run_random_phase(PHASE_ITEMS);

    @(negedge clk);
    in_valid <= 1'b0;
    while (walk_pred.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (walk_pred.due_results.size() != 0) begin
      $error("%0d expected results never arrived", walk_pred.due_results.size());
      walk_pred.failures++;
    end
    if (walk_pred.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
